>>> rtl/core/bfsp_pkg.sv
// bfsp_pkg: shared constants, request types and state encoding
// for the shortest path block. No dependencies.
`default_nettype none

package bfsp_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 1024;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int VcW         = $clog2(MaxVertices + 1);
  localparam int EdgeAW      = $clog2(MaxEdges);
  localparam int EdgeCntW    = $clog2(MaxEdges + 1);
  localparam int WeightW     = 16;
  localparam int DistW       = 40;
  localparam int VcMin       = 2;

  localparam logic signed [DistW-1:0] DistMax = {1'b0, {(DistW-1){1'b1}}};
  localparam logic signed [DistW-1:0] DistMin = {1'b1, {(DistW-1){1'b0}}};

  localparam logic RegVertexCount = 1'b0;
  localparam logic RegSourceVertex = 1'b1;

  typedef struct packed {
    logic [VtxW-1:0]           edge_from;
    logic [VtxW-1:0]           edge_to;
    logic signed [WeightW-1:0] edge_weight;
    logic                      last_edge;
  } in_req_t;

  typedef struct packed {
    logic [VtxW-1:0]         vertex;
    logic                    reachable;
    logic signed [DistW-1:0] distance;
    logic [VtxW-1:0]         parent;
    logic                    has_parent;
    logic                    negative_cycle;
    logic                    last;
  } out_req_t;

  typedef struct packed {
    logic [VtxW-1:0]           tail;
    logic [VtxW-1:0]           head;
    logic signed [WeightW-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [VtxW-1:0]         parent;
    logic signed [DistW-1:0] path_dist;
  } vtx_entry_t;

  typedef struct packed {
    logic                    improve;
    logic signed [DistW-1:0] cand;
  } relax_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_EREAD,
    S_VREAD,
    S_RELAX,
    S_OREAD,
    S_OLOAD
  } state_e;

endpackage

`default_nettype wire

>>> rtl/core/bfsp_edge_mem.sv
// bfsp_edge_mem: edge store, one write and one registered read port.
// Depends on bfsp_pkg.
`default_nettype none

module bfsp_edge_mem
  import bfsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [EdgeAW-1:0] waddr_i,
  input  edge_t             wdata_i,
  input  logic [EdgeAW-1:0] raddr_i,
  output edge_t             rdata_o
);

  edge_t mem_q [MaxEdges];
  edge_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bfsp_vtx_mem.sv
// bfsp_vtx_mem: per-vertex distance and parent store, one write port
// and two registered read ports. Depends on bfsp_pkg.
`default_nettype none

module bfsp_vtx_mem
  import bfsp_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [VtxW-1:0] waddr_i,
  input  vtx_entry_t      wdata_i,
  input  logic [VtxW-1:0] raddr_a_i,
  input  logic [VtxW-1:0] raddr_b_i,
  output vtx_entry_t      rdata_a_o,
  output vtx_entry_t      rdata_b_o
);

  vtx_entry_t mem_q [MaxVertices];
  vtx_entry_t rdata_a_q;
  vtx_entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

>>> rtl/core/bfsp_relax.sv
// bfsp_relax: saturating candidate distance and improvement test for one edge.
// Depends on bfsp_pkg.
`default_nettype none

module bfsp_relax
  import bfsp_pkg::*;
(
  input  edge_t                   edge_i,
  input  logic [VcW-1:0]          vc_i,
  input  logic                    tail_reached_i,
  input  logic                    head_reached_i,
  input  logic signed [DistW-1:0] tail_dist_i,
  input  logic signed [DistW-1:0] head_dist_i,
  output relax_t                  result_o
);

  logic [DistW:0]          sum;
  logic signed [DistW-1:0] cand;
  logic                    in_range;

  always_comb begin
    sum = {tail_dist_i[DistW-1], tail_dist_i}
        + {{(DistW + 1 - WeightW){edge_i.weight[WeightW-1]}}, edge_i.weight};
    if (sum[DistW] != sum[DistW-1]) begin
      cand = sum[DistW] ? DistMin : DistMax;
    end else begin
      cand = sum[DistW-1:0];
    end
    in_range = (VcW'(edge_i.tail) < vc_i) && (VcW'(edge_i.head) < vc_i);
    result_o.cand    = cand;
    result_o.improve = in_range && tail_reached_i && (!head_reached_i || (cand < head_dist_i));
  end

endmodule

`default_nettype wire

>>> rtl/core/bellman_ford_shortest_paths.sv
// bellman_ford_shortest_paths: top level with register port, run sequencer and
// output register. Depends on bfsp_pkg, bfsp_edge_mem, bfsp_vtx_mem, bfsp_relax.
// Edges load at one request per cycle into a 1024-entry edge store; the request
// marked last_edge starts a run and the input stalls until all results are
// out. A run first clears reachability in S_INIT, then each pass walks the
// stored edges in load order through S_EREAD (edge store read), S_VREAD
// (distance reads of tail and head) and S_RELAX (compare and write back), for
// at most vertex_count-1 passes and one check pass. Results follow one per
// vertex in ascending order, each through S_OREAD and S_OLOAD, throttled by
// out_stall_i. Each relaxation reads and writes the single vertex memory in
// turn. No clearing pass is needed after reset.
`default_nettype none

module bellman_ford_shortest_paths
  import bfsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_req_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e               state_q, state_d;
  logic [VcW-1:0]       vcount_q;
  logic [VtxW-1:0]      src_q;
  logic [VcW-1:0]       vc_q, vc_d;
  logic [EdgeCntW-1:0]  cnt_q, cnt_d;
  logic [EdgeAW-1:0]    k_q, k_d;
  logic [VcW-1:0]       pass_q, pass_d;
  logic [VtxW-1:0]      v_q, v_d;
  logic                 changed_q, changed_d;
  logic                 check_q, check_d;
  logic                 neg_q, neg_d;
  logic [MaxVertices-1:0] reached_q, reached_d;
  logic [MaxVertices-1:0] pvalid_q, pvalid_d;
  logic                 out_valid_q, out_valid_d;
  out_req_t             out_q, out_d;

  logic                 in_acc;
  logic                 cfg_wr;
  logic                 edge_we;
  edge_t                edge_wdata;
  edge_t                edge_rd;
  logic                 vtx_we;
  logic [VtxW-1:0]      vtx_waddr;
  vtx_entry_t           vtx_wdata;
  logic [VtxW-1:0]      vtx_raddr_a;
  vtx_entry_t           vtx_rd_a;
  vtx_entry_t           vtx_rd_b;
  relax_t               relax;
  logic                 last_of_pass;
  logic                 out_free;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSourceVertex) ? {{(32-VtxW){1'b0}}, src_q}
                                                 : {{(32-VcW){1'b0}}, vcount_q};

  // register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VcW'(MaxVertices);
      src_q    <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegVertexCount) begin
        vcount_q <= pwdata[VcW-1:0];
      end else begin
        src_q <= pwdata[VtxW-1:0];
      end
    end
  end

  assign edge_we    = in_acc && (cnt_q < EdgeCntW'(MaxEdges));
  assign edge_wdata = '{tail: in_data_i.edge_from, head: in_data_i.edge_to,
                        weight: in_data_i.edge_weight};

  bfsp_edge_mem u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (cnt_q[EdgeAW-1:0]),
    .wdata_i (edge_wdata),
    .raddr_i (k_q),
    .rdata_o (edge_rd)
  );

  assign vtx_raddr_a = ((state_q == S_OREAD) || (state_q == S_OLOAD)) ? v_q : edge_rd.tail;

  bfsp_vtx_mem u_vtx_mem (
    .clk_i     (clk_i),
    .we_i      (vtx_we),
    .waddr_i   (vtx_waddr),
    .wdata_i   (vtx_wdata),
    .raddr_a_i (vtx_raddr_a),
    .raddr_b_i (edge_rd.head),
    .rdata_a_o (vtx_rd_a),
    .rdata_b_o (vtx_rd_b)
  );

  bfsp_relax u_relax (
    .edge_i         (edge_rd),
    .vc_i           (vc_q),
    .tail_reached_i (reached_q[edge_rd.tail]),
    .head_reached_i (reached_q[edge_rd.head]),
    .tail_dist_i    (vtx_rd_a.path_dist),
    .head_dist_i    (vtx_rd_b.path_dist),
    .result_o       (relax)
  );

  assign last_of_pass = (EdgeCntW'(k_q) + EdgeCntW'(1)) == cnt_q;
  assign out_free     = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= VcW'(MaxVertices);
      cnt_q       <= '0;
      k_q         <= '0;
      pass_q      <= '0;
      v_q         <= '0;
      changed_q   <= 1'b0;
      check_q     <= 1'b0;
      neg_q       <= 1'b0;
      reached_q   <= '0;
      pvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      pass_q      <= pass_d;
      v_q         <= v_d;
      changed_q   <= changed_d;
      check_q     <= check_d;
      neg_q       <= neg_d;
      reached_q   <= reached_d;
      pvalid_q    <= pvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    vc_d        = vc_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    pass_d      = pass_q;
    v_d         = v_q;
    changed_d   = changed_q;
    check_d     = check_q;
    neg_d       = neg_q;
    reached_d   = reached_q;
    pvalid_d    = pvalid_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    vtx_we      = 1'b0;
    vtx_waddr   = edge_rd.head;
    vtx_wdata   = '{parent: edge_rd.tail, path_dist: relax.cand};
    in_stall_o  = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_stall_o = out_valid_q;
        if (in_acc) begin
          if (edge_we) begin
            cnt_d = cnt_q + EdgeCntW'(1);
          end
          if (in_data_i.last_edge) begin
            if (vcount_q < VcW'(VcMin)) begin
              vc_d = VcW'(VcMin);
            end else if (vcount_q > VcW'(MaxVertices)) begin
              vc_d = VcW'(MaxVertices);
            end else begin
              vc_d = vcount_q;
            end
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        reached_d = '0;
        pvalid_d  = '0;
        if (VcW'(src_q) < vc_q) begin
          reached_d[src_q] = 1'b1;
          vtx_we    = 1'b1;
          vtx_waddr = src_q;
          vtx_wdata = '{parent: '0, path_dist: '0};
        end
        pass_d    = VcW'(1);
        k_d       = '0;
        changed_d = 1'b0;
        check_d   = 1'b0;
        neg_d     = 1'b0;
        state_d   = S_EREAD;
      end
      S_EREAD: begin
        state_d = S_VREAD;
      end
      S_VREAD: begin
        state_d = S_RELAX;
      end
      S_RELAX: begin
        if (check_q) begin
          if (relax.improve || last_of_pass) begin
            neg_d   = relax.improve;
            v_d     = '0;
            cnt_d   = '0;
            state_d = S_OREAD;
          end else begin
            k_d     = k_q + EdgeAW'(1);
            state_d = S_EREAD;
          end
        end else begin
          if (relax.improve) begin
            vtx_we                  = 1'b1;
            reached_d[edge_rd.head] = 1'b1;
            pvalid_d[edge_rd.head]  = 1'b1;
            changed_d               = 1'b1;
          end
          state_d = S_EREAD;
          if (last_of_pass) begin
            k_d       = '0;
            changed_d = 1'b0;
            if (!(changed_q || relax.improve) || (pass_q + VcW'(1)) == vc_q) begin
              check_d = 1'b1;
            end else begin
              pass_d = pass_q + VcW'(1);
            end
          end else begin
            k_d = k_q + EdgeAW'(1);
          end
        end
      end
      S_OREAD: begin
        state_d = S_OLOAD;
      end
      S_OLOAD: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.vertex         = v_q;
          out_d.reachable      = reached_q[v_q];
          out_d.distance       = reached_q[v_q] ? vtx_rd_a.path_dist : '0;
          out_d.parent         = pvalid_q[v_q] ? vtx_rd_a.parent : '0;
          out_d.has_parent     = pvalid_q[v_q];
          out_d.negative_cycle = neg_q;
          out_d.last           = (VcW'(v_q) + VcW'(1)) == vc_q;
          if ((VcW'(v_q) + VcW'(1)) == vc_q) begin
            state_d = S_IDLE;
          end else begin
            v_d     = v_q + VtxW'(1);
            state_d = S_OREAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // vertex store is written only by the start of a run or a relaxation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_we |-> (state_q == S_INIT) || ((state_q == S_RELAX) && !check_q))
    else $error("vertex store written outside a relaxation");

  // the final result names the last vertex in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> (VcW'(out_data_o.vertex) + VcW'(1)) == vc_q)
    else $error("last result does not match vertex count");

  // pass counter stays below the vertex count while relaxing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELAX) |-> (pass_q < vc_q) && (pass_q != '0))
    else $error("pass counter out of range");

  // the negative cycle flag holds for the whole output phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OLOAD) && ($past(state_q) == S_OREAD) |-> $stable(neg_q))
    else $error("negative cycle flag changed during output");

  // edge count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= EdgeCntW'(MaxEdges))
    else $error("edge count beyond store depth");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// tb_top: self-checking bench for bellman_ford_shortest_paths, with its own
// shortest path predictor, random edge lists and apb register writes.
// Depends on bfsp_pkg and the rtl of bellman_ford_shortest_paths.
`timescale 1ns / 100ps

module tb_top
  import bfsp_pkg::*;
();

  localparam int RandomItems = 140;
  localparam int CalmItems   = 40;
  localparam int DrainCycles = 32;

  class path_scoreboard;
    edge_t                edge_mem[MaxEdges];
    int unsigned          n_edges;
    logic [VcW-1:0]       vc_reg  = VcW'(MaxVertices);
    logic [VtxW-1:0]      src_reg = '0;
    longint               path_len[MaxVertices];
    bit                   reached[MaxVertices];
    bit                   has_pred[MaxVertices];
    logic [VtxW-1:0]      pred[MaxVertices];
    out_req_t             expected_q[$];
    int                   errors;

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == RegVertexCount) vc_reg = value[VcW-1:0];
      else src_reg = value[VtxW-1:0];
    endfunction

    function longint sat_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (s > longint'(DistMax)) return longint'(DistMax);
      if (s < longint'(DistMin)) return longint'(DistMin);
      return s;
    endfunction

    function bit relaxes(edge_t e, int vc, output longint cand);
      longint w;
      cand = 0;
      w = e.weight;
      if (e.tail >= vc || e.head >= vc) return 1'b0;
      if (!reached[e.tail]) return 1'b0;
      cand = sat_sum(path_len[e.tail], w);
      return !reached[e.head] || cand < path_len[e.head];
    endfunction

    function void note_request(in_req_t req);
      int       vc;
      int       pass;
      int       k;
      int       v;
      bit       changed;
      bit       neg;
      longint   cand;
      out_req_t res;
      if (n_edges < MaxEdges) begin
        edge_mem[n_edges].tail   = req.edge_from;
        edge_mem[n_edges].head   = req.edge_to;
        edge_mem[n_edges].weight = req.edge_weight;
        n_edges++;
      end
      if (!req.last_edge) return;
      vc = (vc_reg < VcMin) ? VcMin : (vc_reg > MaxVertices) ? MaxVertices : int'(vc_reg);
      for (v = 0; v < MaxVertices; v++) begin
        path_len[v] = 0;
        reached[v]  = 1'b0;
        has_pred[v] = 1'b0;
        pred[v]     = '0;
      end
      if (src_reg < vc) reached[src_reg] = 1'b1;
      for (pass = 1; pass < vc; pass++) begin
        changed = 1'b0;
        for (k = 0; k < n_edges; k++) begin
          if (relaxes(edge_mem[k], vc, cand)) begin
            path_len[edge_mem[k].head] = cand;
            reached[edge_mem[k].head]  = 1'b1;
            has_pred[edge_mem[k].head] = 1'b1;
            pred[edge_mem[k].head]     = edge_mem[k].tail;
            changed = 1'b1;
          end
        end
        if (!changed) break;
      end
      neg = 1'b0;
      for (k = 0; k < n_edges; k++) begin
        if (relaxes(edge_mem[k], vc, cand)) begin
          neg = 1'b1;
          break;
        end
      end
      for (v = 0; v < vc; v++) begin
        res.vertex         = v[VtxW-1:0];
        res.reachable      = reached[v];
        res.distance       = reached[v] ? path_len[v][DistW-1:0] : '0;
        res.parent         = has_pred[v] ? pred[v] : '0;
        res.has_parent     = has_pred[v];
        res.negative_cycle = neg;
        res.last           = (v == vc - 1);
        expected_q.push_back(res);
      end
      n_edges = 0;
    endfunction

    function void compare_field(string what, logic signed [DistW-1:0] want,
                                logic signed [DistW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      string    tag;
      if (expected_q.size() == 0) begin
        $display("%0t: result expected none got %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      tag  = $sformatf("vertex %0d", want.vertex);
      compare_field({tag, " vertex"}, want.vertex, got.vertex);
      compare_field({tag, " reachable"}, want.reachable, got.reachable);
      compare_field({tag, " distance"}, want.distance, got.distance);
      compare_field({tag, " parent"}, want.parent, got.parent);
      compare_field({tag, " has_parent"}, want.has_parent, got.has_parent);
      compare_field({tag, " negative_cycle"}, want.negative_cycle, got.negative_cycle);
      compare_field({tag, " last"}, want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_req_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_req_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  path_scoreboard sb;
  bit             calm;
  int             cur_vc;
  int             cur_src;

  bellman_ford_shortest_paths dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #(8_000_000);
    $display("tb_top failed");
    $finish;
  end

  // result side: random stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          out_stall_i = 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_result(out_data_o);
    end
  end

  task automatic send_edge(logic [VtxW-1:0] from_v, logic [VtxW-1:0] to_v,
                           logic signed [WeightW-1:0] w, logic last_e);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_data_i.edge_from   = from_v;
    in_data_i.edge_to     = to_v;
    in_data_i.edge_weight = w;
    in_data_i.last_edge   = last_e;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(in_data_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == RegVertexCount) ? 32'h7f : 32'h3f;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_register(idx, value);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.compare_field($sformatf("register %0d readback", idx), value & mask, prdata & mask);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(int vc, int src);
    write_register(RegVertexCount, vc);
    write_register(RegSourceVertex, src);
    cur_vc  = (vc < VcMin) ? VcMin : (vc > MaxVertices) ? MaxVertices : vc;
    cur_src = src;
  endtask

  task automatic send_random_graph(int n);
    logic [VtxW-1:0]           tail;
    logic [VtxW-1:0]           head;
    logic [VtxW-1:0]           prev_head;
    logic signed [WeightW-1:0] w;
    int                        pick;
    prev_head = VtxW'(cur_src);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) tail = VtxW'(cur_src);
      else if (pick < 7) tail = prev_head;
      else if (pick < 9) tail = VtxW'($urandom_range(0, cur_vc - 1));
      else tail = VtxW'($urandom);
      head = ($urandom_range(0, 9) == 0) ? VtxW'($urandom)
                                         : VtxW'($urandom_range(0, cur_vc - 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) w = WeightW'($urandom_range(0, 50));
      else if (pick < 8) w = WeightW'(-$urandom_range(1, 20));
      else if (pick < 9) w = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      else w = WeightW'($urandom);
      prev_head = head;
      send_edge(tail, head, w, k == n - 1);
    end
  endtask

  initial begin
    int n_random;
    int n;
    int pick;
    int vc;
    sb          = new();
    calm        = 1'b0;
    cur_vc      = MaxVertices;
    cur_src     = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, extreme weights, edge to the highest vertex
    send_edge(0, 1, 16'sh7fff, 1'b0);
    send_edge(1, 2, 16'sh7fff, 1'b0);
    send_edge(0, 63, 16'sh8000, 1'b1);
    wait_idle();

    configure(5, 1);
    send_edge(1, 2, 5, 1'b0);
    send_edge(2, 3, -3, 1'b0);
    send_edge(1, 3, 4, 1'b0);
    send_edge(3, 4, 16'sh8000, 1'b0);
    send_edge(63, 0, 1, 1'b0);
    send_edge(4, 63, 7, 1'b1);
    // single self loop
    send_edge(1, 1, 0, 1'b1);
    // source on a negative cycle
    send_edge(1, 2, -4, 1'b0);
    send_edge(2, 1, 1, 1'b0);
    send_edge(2, 0, 100, 1'b1);
    wait_idle();

    // vertex count below the minimum
    configure(0, 1);
    send_edge(1, 0, 16'sh8000, 1'b0);
    send_edge(0, 1, 16'sh7fff, 1'b1);
    wait_idle();

    // vertex count above the maximum
    configure(127, 63);
    send_edge(63, 0, -1, 1'b0);
    send_edge(0, 62, 0, 1'b1);
    wait_idle();

    // source outside the graph
    configure(10, 63);
    send_edge(63, 1, 1, 1'b0);
    send_edge(1, 2, 2, 1'b1);
    wait_idle();

    configure(1, 0);
    send_edge(0, 1, -7, 1'b1);
    wait_idle();
    configure(64, 0);

    n_random = 0;
    while (n_random < RandomItems) begin
      if (n_random >= RandomItems - CalmItems) calm = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        wait_idle();
        pick = $urandom_range(0, 9);
        if (pick == 0) vc = $urandom_range(0, 1);
        else if (pick == 1) vc = MaxVertices;
        else if (pick == 2) vc = $urandom_range(MaxVertices + 1, 127);
        else vc = $urandom_range(2, 16);
        n = (vc < VcMin) ? VcMin : (vc > MaxVertices) ? MaxVertices : vc;
        configure(vc, ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, n - 1));
      end else if (pick == 4) begin
        wait_idle();
      end
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      send_random_graph(n);
      n_random += n;
    end
    wait_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bfsp_pkg.sv
rtl/core/bfsp_edge_mem.sv
rtl/core/bfsp_vtx_mem.sv
rtl/core/bfsp_relax.sv
rtl/core/bellman_ford_shortest_paths.sv
sim/tb_top.sv
